[hw/rtl/sbm_pkg.sv]
// Package for the stack bytecode machine: opcodes, status codes, FSM states
// and the divider status struct. No dependencies.
`default_nettype none

package sbm_pkg;

  // Default operand stack depth
  localparam int unsigned STACK_DEPTH_DEF = 256;

  // Data word width of the operand stack
  localparam int unsigned WORD_W = 32;

  // Instruction codes
  localparam logic [7:0] OPC_PUSH  = 8'h01;
  localparam logic [7:0] OPC_ADD   = 8'h02;
  localparam logic [7:0] OPC_SUB   = 8'h03;
  localparam logic [7:0] OPC_MUL   = 8'h04;
  localparam logic [7:0] OPC_DIV   = 8'h05;
  localparam logic [7:0] OPC_PRINT = 8'h06;
  localparam logic [7:0] OPC_HALT  = 8'h07;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_UNDER    = 3'd2;
  localparam logic [2:0] ST_DIVZERO  = 3'd3;
  localparam logic [2:0] ST_INVALID  = 3'd4;
  localparam logic [2:0] ST_HALTED   = 3'd5;
  localparam logic [2:0] ST_IGNORED  = 3'd6;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_B,
    S_RD_A,
    S_DIV,
    S_OUT
  } sbm_state_t;

  // Divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage : sbm_pkg

`default_nettype wire

[hw/rtl/sbm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sbm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : sbm_ram

`default_nettype wire

[hw/rtl/sbm_div.sv]
// Iterative signed 32-bit divider, truncating toward zero, one quotient bit
// per cycle. Depends on sbm_pkg.
`default_nettype none

module sbm_div
  import sbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic      [WORD_W-1:0] quotient,
  output div_stat_t              stat
);

  localparam int unsigned CW = $clog2(WORD_W);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic [WORD_W-1:0] quo_r, quo_nxt;
  logic [WORD_W-1:0] dvs_r, dvs_nxt;
  logic            neg_r, neg_nxt;
  logic [WORD_W-1:0] q_r, q_nxt;

  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   rem_dif;
  logic              ge;
  logic [WORD_W-1:0] quo_step;

  // One restoring step
  assign rem_sh   = {rem_r, quo_r[WORD_W-1]};
  assign rem_dif  = rem_sh - {1'b0, dvs_r};
  assign ge       = (rem_sh >= {1'b0, dvs_r});
  assign quo_step = {quo_r[WORD_W-2:0], ge};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    if (start) begin
      // Load magnitudes and the sign of the quotient
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      dvs_nxt  = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
      neg_nxt  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (busy_r) begin
      // Advance one bit
      rem_nxt = ge ? rem_dif[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      quo_nxt = quo_step;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        q_nxt    = neg_r ? (WORD_W'(0) - quo_step) : quo_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule : sbm_div

`default_nettype wire

[hw/rtl/stack_bytecode_machine.sv]
// Stack bytecode machine top level: sequencer, operand stack RAM and divider.
// Depends on sbm_pkg, sbm_ram and sbm_div.
//
//  channel | direction | tdata fields (lowest bit up)
//  in_     | slave     | opcode[7:0], immediate[39:8]
//  out_    | master    | status[2:0], print_valid[3], print_value[35:4], zero[39:36]
//
// Each item runs from the accept cycle to the load of the result register. Push,
// halt, invalid opcodes, underflows and ignored items go straight to the output
// state; print reads one stack entry; add, sub, mul and divide by zero read two;
// div also waits on the bit-serial divider, then writes back. The stack RAM's
// single read port sets the operand fetch, one operand per cycle. A new item is
// accepted once the sequencer is back in idle, even while the previous result
// waits on out_tready. Reset (synchronous, rst_n low) empties the stack and
// resumes running; the stack RAM is not cleared.
`default_nettype none

module stack_bytecode_machine
  import sbm_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // opcode[7:0], immediate[39:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata   // status[2:0], print_valid[3], print_value[35:4]
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  sbm_state_t state_r, state_nxt;

  logic [DW-1:0]     depth_r, depth_nxt;
  logic              stopped_r, stopped_nxt;
  logic [7:0]        op_r, op_nxt;
  logic [WORD_W-1:0] b_r, b_nxt;
  logic [2:0]        res_status_r, res_status_nxt;
  logic              res_pvalid_r, res_pvalid_nxt;
  logic [WORD_W-1:0] res_pvalue_r, res_pvalue_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_status_r;
  logic              out_pvalid_r;
  logic [WORD_W-1:0] out_pvalue_r;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] rd_data;

  logic              div_start;
  logic [WORD_W-1:0] div_q;
  div_stat_t         div_st;

  logic [7:0]        in_opcode;
  logic [WORD_W-1:0] in_immediate;
  logic              in_acc;
  logic              is_bin;
  logic              stack_full;
  logic [DW-1:0]     depth_m1;
  logic [DW-1:0]     depth_m2;
  logic [WORD_W-1:0] mul_lo;
  logic              out_load;

  assign in_opcode    = in_tdata[7:0];
  assign in_immediate = in_tdata[39:8];
  assign in_tready    = (state_r == S_IDLE);
  assign in_acc       = in_tvalid && in_tready;
  assign is_bin       = in_opcode inside {[OPC_ADD:OPC_DIV]};
  assign stack_full   = (depth_r == DW'(STACK_DEPTH));
  assign depth_m1     = depth_r - DW'(1);
  assign depth_m2     = depth_r - DW'(2);
  assign mul_lo       = rd_data * b_r;
  assign out_load     = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // Operand stack
  sbm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Divider
  sbm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data),
    .divisor  (b_r),
    .quotient (div_q),
    .stat     (div_st)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (stopped_r) begin
            state_nxt = S_OUT;
          end else if (is_bin) begin
            state_nxt = (depth_r < DW'(2)) ? S_OUT : S_RD_B;
          end else if (in_opcode == OPC_PRINT) begin
            state_nxt = (depth_r == '0) ? S_OUT : S_RD_B;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RD_B: begin
        state_nxt = (op_r == OPC_PRINT) ? S_OUT : S_RD_A;
      end
      S_RD_A: begin
        state_nxt = ((op_r == OPC_DIV) && (b_r != '0)) ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (div_st.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    depth_nxt      = depth_r;
    stopped_nxt    = stopped_r;
    op_nxt         = op_r;
    b_nxt          = b_r;
    res_status_nxt = res_status_r;
    res_pvalid_nxt = res_pvalid_r;
    res_pvalue_nxt = res_pvalue_r;
    mem_we         = 1'b0;
    mem_waddr      = depth_m2[AW-1:0];
    mem_wdata      = rd_data;
    mem_raddr      = depth_m1[AW-1:0];
    div_start      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_opcode;
          res_status_nxt = ST_OK;
          res_pvalid_nxt = 1'b0;
          res_pvalue_nxt = '0;
          if (stopped_r) begin
            res_status_nxt = ST_IGNORED;
          end else if (in_opcode == OPC_PUSH) begin
            if (stack_full) begin
              res_status_nxt = ST_OVERFLOW;
              stopped_nxt    = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = depth_r[AW-1:0];
              mem_wdata = in_immediate;
              depth_nxt = depth_r + DW'(1);
            end
          end else if (is_bin) begin
            if (depth_r < DW'(2)) begin
              res_status_nxt = ST_UNDER;
              stopped_nxt    = 1'b1;
            end
          end else if (in_opcode == OPC_PRINT) begin
            if (depth_r == '0) begin
              res_status_nxt = ST_UNDER;
              stopped_nxt    = 1'b1;
            end else begin
              depth_nxt = depth_m1;
            end
          end else if (in_opcode == OPC_HALT) begin
            res_status_nxt = ST_HALTED;
            stopped_nxt    = 1'b1;
          end else begin
            res_status_nxt = ST_INVALID;
            stopped_nxt    = 1'b1;
          end
        end
      end
      S_RD_B: begin
        // Top entry is on the read port; fetch the one below
        mem_raddr = depth_m2[AW-1:0];
        b_nxt     = rd_data;
        if (op_r == OPC_PRINT) begin
          res_pvalid_nxt = 1'b1;
          res_pvalue_nxt = rd_data;
        end
      end
      S_RD_A: begin
        case (op_r)
          OPC_ADD: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data + b_r;
            depth_nxt = depth_m1;
          end
          OPC_SUB: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data - b_r;
            depth_nxt = depth_m1;
          end
          OPC_MUL: begin
            mem_we    = 1'b1;
            mem_wdata = mul_lo;
            depth_nxt = depth_m1;
          end
          default: begin
            if (b_r == '0) begin
              res_status_nxt = ST_DIVZERO;
              stopped_nxt    = 1'b1;
            end else begin
              div_start = 1'b1;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_st.done) begin
          mem_we    = 1'b1;
          mem_wdata = div_q;
          depth_nxt = depth_m1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load the pending result, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    b_r          <= b_nxt;
    res_status_r <= res_status_nxt;
    res_pvalid_r <= res_pvalid_nxt;
    res_pvalue_r <= res_pvalue_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_pvalid_r <= res_pvalid_r;
      out_pvalue_r <= res_pvalue_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_pvalue_r, out_pvalid_r, out_status_r};

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped flag cleared without reset");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    (div_st.busy || div_st.done) |-> (state_r == S_DIV))
    else $error("divider active outside divide state");

  a_print_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[3]) |-> (out_tdata[35:4] == '0))
    else $error("print value non-zero without print");
`endif

endmodule : stack_bytecode_machine

`default_nettype wire
